// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define RRPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rrps: implication check failed");

// Next-cycle implication under reset.
`define RRPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rrps: next-cycle check failed");

`endif

// ===== design/rrps_pkg.sv =====
// Package for the round-robin PRB share scheduler: sizes, register map,
// controller states and the command/status structs. Depends on nothing.
package rrps_pkg;

	localparam int NUM_SENDERS = 16;
	localparam int MAX_BLOCKS  = 275;

	localparam int MASK_W = 16;
	localparam int ID_W   = 4;
	localparam int BLK_W  = 9;
	localparam int CNT_W  = $clog2(MASK_W + 1);
	localparam int STEP_W = $clog2(BLK_W + 1);

	localparam logic [MASK_W-1:0] SENDER_MASK = (NUM_SENDERS >= MASK_W) ? '1 :
		MASK_W'((64'd1 << NUM_SENDERS) - 64'd1);

	localparam logic [BLK_W-1:0] TOTAL_RESET = BLK_W'(275);

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_TOTAL_BLOCKS = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic walk_step;
	} cmd_t;

	typedef struct packed {
		logic in_zero;
		logic div_last;
		logic emit;
		logic out_free;
		logic walk_last;
	} stat_t;

endpackage

// ===== design/rrps_if.sv =====
// Valid/ready channel interfaces for slot masks and grants.
// Depends on rrps_pkg.
interface rrps_in_if;
	logic                         valid;
	logic                         ready;
	logic [rrps_pkg::MASK_W-1:0]  active_mask;

	modport source (output valid, output active_mask, input ready);
	modport sink (input valid, input active_mask, output ready);
endinterface

interface rrps_out_if;
	logic                        valid;
	logic                        ready;
	logic [rrps_pkg::ID_W-1:0]   sender_id;
	logic [rrps_pkg::BLK_W-1:0]  first_block;
	logic [rrps_pkg::BLK_W-1:0]  block_count;
	logic                        last_grant;

	modport source (output valid, output sender_id, output first_block,
		output block_count, output last_grant, input ready);
	modport sink (input valid, input sender_id, input first_block,
		input block_count, input last_grant, output ready);
endinterface

// ===== design/round_robin_prb_share_scheduler_core.sv =====
// Top level of the round-robin PRB share scheduler.
// Depends on rrps_pkg, rrps_if, rrps_cfg, rrps_ctrl, rrps_dp, assert_macros.svh.
//
// Usage:
//   in_ch carries one slot's active_mask per transfer; out_ch carries one
//   grant (sender_id, first_block, block_count, last_grant) per transfer.
//   Grants of a slot come in round-robin order from the stored start
//   pointer; last_grant marks the final grant of the slot.
//   total_blocks is written over the APB port (address 0); the user must
//   write it only while idle, as the block itself does not enforce this.
//   A nonzero mask is accepted, passes through the bit-serial share divider,
//   then gives one grant per cycle through the walk while the receiver takes
//   them, plus one more silent walk step when the new start pointer lies past
//   the last grant. A slot gives at most 16 grants with 16 senders.
//   An all-zero mask is accepted while idle and gives no grant.
//   The next mask is accepted while the final grant still waits in the
//   output register. A stalled receiver holds the walk at the pending grant.
//   Reset clears the start pointer to zero, total_blocks to 275 and drops
//   any pending grant.
`include "assert_macros.svh"

module round_robin_prb_share_scheduler_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rrps_pkg::ADDR_W-1:0]  paddr,
	input  logic [rrps_pkg::DATA_W-1:0]  pwdata,
	output logic [rrps_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	rrps_in_if.sink                      in_ch,
	rrps_out_if.source                   out_ch
);

	logic [rrps_pkg::BLK_W-1:0]  total_blocks;
	logic                        in_ready;
	rrps_pkg::cmd_t              cmd;
	rrps_pkg::stat_t             status;

	rrps_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.total_blocks (total_blocks)
	);

	rrps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rrps_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_mask      (in_ch.active_mask),
		.total_blocks (total_blocks),
		.out_ch       (out_ch)
	);

	assign in_ch.ready = in_ready;

	`RRPS_ASSERT_IMP(a_load_on_xfer, clk, arst_n, cmd.load, in_ch.valid && in_ch.ready)
	`RRPS_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.walk_step && status.emit, status.out_free)
	`RRPS_ASSERT_IMP(a_busy_blocks_in, clk, arst_n, cmd.div_step || cmd.walk_step, !in_ch.ready)
	`RRPS_ASSERT_NXT(a_div_then_walk, clk, arst_n, cmd.div_step && status.div_last, !cmd.div_step)

endmodule

// ===== design/rrps_cfg.sv =====
// APB-style configuration register block holding total_blocks.
// Depends on rrps_pkg.
module rrps_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rrps_pkg::ADDR_W-1:0]  paddr,
	input  logic [rrps_pkg::DATA_W-1:0]  pwdata,
	output logic [rrps_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [rrps_pkg::BLK_W-1:0]   total_blocks
);

	logic                        hit;
	logic                        wr_en;
	logic [rrps_pkg::BLK_W-1:0]  total_q;

	assign pready = 1'b1;
	assign hit    = (paddr[rrps_pkg::ADDR_W-1] == rrps_pkg::REG_TOTAL_BLOCKS);
	assign wr_en  = psel && penable && pwrite && pready && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= rrps_pkg::TOTAL_RESET;
		end else if (wr_en) begin
			total_q <= pwdata[rrps_pkg::BLK_W-1:0];
		end
	end

	assign prdata       = hit ? rrps_pkg::DATA_W'(total_q) : '0;
	assign total_blocks = total_q;

endmodule

// ===== design/rrps_ctrl.sv =====
// Controller state machine: accept a slot, run the divider, walk the grants.
// Depends on rrps_pkg.
module rrps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rrps_pkg::stat_t  status,
	output rrps_pkg::cmd_t   cmd
);

	rrps_pkg::state_t state_q;
	rrps_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			rrps_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !status.in_zero) begin
					cmd.load = 1'b1;
					state_d  = rrps_pkg::ST_DIV;
				end
			end
			rrps_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = rrps_pkg::ST_WALK;
				end
			end
			rrps_pkg::ST_WALK: begin
				if (!status.emit || status.out_free) begin
					cmd.walk_step = 1'b1;
					if (status.walk_last) begin
						state_d = rrps_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = rrps_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/rrps_dp.sv =====
// Datapath: sender count, bit-serial share divider, rotated grant walk,
// start pointer and grant output register. Depends on rrps_pkg, rrps_if.
module rrps_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrps_pkg::cmd_t                cmd,
	output rrps_pkg::stat_t               status,
	input  logic [rrps_pkg::MASK_W-1:0]   in_mask,
	input  logic [rrps_pkg::BLK_W-1:0]    total_blocks,
	rrps_out_if.source                    out_ch
);

	localparam int MASK_W = rrps_pkg::MASK_W;
	localparam int ID_W   = rrps_pkg::ID_W;
	localparam int BLK_W  = rrps_pkg::BLK_W;
	localparam int CNT_W  = rrps_pkg::CNT_W;
	localparam int STEP_W = rrps_pkg::STEP_W;

	logic [MASK_W-1:0]  mask_in;
	logic [CNT_W-1:0]   n_in;
	logic [BLK_W-1:0]   t_clamp;
	logic [CNT_W-1:0]   sched_in;

	logic [ID_W-1:0]    ptr_q;
	logic [STEP_W-1:0]  div_cnt_q;
	logic               out_valid_q;

	logic [MASK_W-1:0]  rot_q;
	logic [ID_W-1:0]    base_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   sched_q;
	logic [BLK_W-1:0]   div_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   idx_q;
	logic [BLK_W-1:0]   pos_q;

	logic [ID_W-1:0]    sender_q;
	logic [BLK_W-1:0]   first_q;
	logic [BLK_W-1:0]   count_q;
	logic               last_q;

	logic [CNT_W:0]     trial;
	logic               trial_ge;
	logic [ID_W-1:0]    off;
	logic [ID_W-1:0]    grant_id;
	logic [BLK_W-1:0]   grant_cnt;
	logic [CNT_W-1:0]   adv_pos;
	logic               grant_last;
	logic               out_xfer;

	assign mask_in = in_mask & rrps_pkg::SENDER_MASK;

	always_comb begin
		n_in = '0;
		for (int i = 0; i < MASK_W; i++) begin
			n_in = n_in + CNT_W'(mask_in[i]);
		end
	end

	always_comb begin
		if (total_blocks == '0) begin
			t_clamp = BLK_W'(1);
		end else if (int'(total_blocks) > rrps_pkg::MAX_BLOCKS) begin
			t_clamp = BLK_W'(rrps_pkg::MAX_BLOCKS);
		end else begin
			t_clamp = total_blocks;
		end
	end

	assign sched_in = (BLK_W'(n_in) < t_clamp) ? n_in : t_clamp[CNT_W-1:0];

	assign trial    = {rem_q, div_q[BLK_W-1]};
	assign trial_ge = (trial >= {1'b0, sched_q});

	always_comb begin
		off = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (rot_q[i]) begin
				off = ID_W'(i);
			end
		end
	end

	assign grant_id   = base_q + off;
	assign grant_cnt  = div_q + BLK_W'(idx_q < rem_q);
	assign grant_last = ((CNT_W + 1)'(idx_q) + (CNT_W + 1)'(1)) == {1'b0, sched_q};

	always_comb begin
		if (n_q == CNT_W'(1)) begin
			adv_pos = '0;
		end else if (rem_q == '0) begin
			adv_pos = CNT_W'(1);
		end else begin
			adv_pos = rem_q;
		end
	end

	assign out_xfer = out_valid_q && out_ch.ready;

	assign status.in_zero   = (mask_in == '0);
	assign status.div_last  = (div_cnt_q == STEP_W'(1));
	assign status.emit      = (idx_q < sched_q);
	assign status.out_free  = !out_valid_q || out_ch.ready;
	assign status.walk_last = ((CNT_W + 1)'(idx_q) + (CNT_W + 1)'(1) >= {1'b0, sched_q})
		&& (idx_q >= adv_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				div_cnt_q <= STEP_W'(BLK_W);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - STEP_W'(1);
			end
			if (cmd.walk_step && (idx_q == adv_pos)) begin
				ptr_q <= grant_id;
			end
			if (cmd.walk_step && status.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rot_q   <= MASK_W'({mask_in, mask_in} >> ptr_q);
			base_q  <= ptr_q;
			n_q     <= n_in;
			sched_q <= sched_in;
			div_q   <= t_clamp;
			rem_q   <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? CNT_W'(trial - {1'b0, sched_q}) : trial[CNT_W-1:0];
			div_q <= {div_q[BLK_W-2:0], trial_ge};
		end else if (cmd.walk_step) begin
			rot_q <= rot_q & ~(MASK_W'(1) << off);
			idx_q <= idx_q + CNT_W'(1);
			if (status.emit) begin
				pos_q    <= pos_q + grant_cnt;
				sender_q <= grant_id;
				first_q  <= pos_q;
				count_q  <= grant_cnt;
				last_q   <= grant_last;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.sender_id   = sender_q;
	assign out_ch.first_block = first_q;
	assign out_ch.block_count = count_q;
	assign out_ch.last_grant  = last_q;

endmodule
